[rtl/core/gac_pkg.sv]
package gac_pkg;

    // result status codes
    localparam logic [2:0] ST_APPENDED   = 3'd0;
    localparam logic [2:0] ST_NEW_GROUP  = 3'd1;
    localparam logic [2:0] ST_COMPLETED  = 3'd2;
    localparam logic [2:0] ST_TABLE_FULL = 3'd3;
    localparam logic [2:0] ST_GROUP_FULL = 3'd4;
    localparam logic [2:0] ST_SWEEP      = 3'd5;
    localparam logic [2:0] ST_NONE       = 3'd6;

    // item modes
    localparam logic MODE_RECORD = 1'b0;
    localparam logic MODE_SWEEP  = 1'b1;

    // stored acknowledgment payload: sender, receiver, stamp
    localparam int ACK_W = 22 + 22 + 32;

    typedef struct packed {
        logic        mode;
        logic [15:0] msg_id;
        logic [21:0] sender_id;
        logic [21:0] receiver_id;
        logic [31:0] stamp;
    } t_in_item;

    typedef struct packed {
        logic [2:0]  status;
        logic [15:0] out_msg_id;
        logic [21:0] out_sender;
        logic [21:0] out_receiver;
        logic [31:0] out_stamp;
        logic        last;
    } t_out_item;

    // controller to datapath commands
    typedef struct packed {
        logic in_load;
        logic mask_load;
        logic rec_commit;
        logic rec_hit;
        logic rec_take;
        logic sw_read;
        logic sw_emit;
        logic sw_last;
        logic sw_done;
        logic none_emit;
    } t_dp_cmd;

    // datapath to controller status
    typedef struct packed {
        logic in_mode;
        logic grp_match;
        logic grp_free;
        logic mask_any;
        logic rest_zero;
        logic out_free;
    } t_dp_stat;

endpackage

[rtl/core/gac_datapath.sv]
module gac_datapath #(
    parameter int GROUPS         = 8,
    parameter int ACKS_PER_GROUP = 5
) (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  gac_pkg::t_in_item  i_in_item,
    input  logic               i_out_stall,
    output logic               o_out_valid,
    output gac_pkg::t_out_item o_out_item,
    input  gac_pkg::t_dp_cmd   i_cmd,
    input  logic [((GROUPS > 1) ? $clog2(GROUPS) : 1)-1:0] i_grp,
    input  logic [$clog2(ACKS_PER_GROUP)-1:0]              i_slot,
    output gac_pkg::t_dp_stat  o_stat,
    output logic [((GROUPS > 1) ? $clog2(GROUPS) : 1)-1:0] o_mask_low
);
    import gac_pkg::*;

    localparam int GW    = (GROUPS > 1) ? $clog2(GROUPS) : 1;
    localparam int CW    = $clog2(ACKS_PER_GROUP + 1);
    localparam int SLOTS = GROUPS * ACKS_PER_GROUP;
    localparam int AW    = $clog2(SLOTS);

    // per-group state: owner id and fill count (zero means free)
    logic [15:0]      r_gid [GROUPS];
    logic [CW-1:0]    r_cnt [GROUPS];
    logic [GROUPS-1:0] r_mask;
    logic [GROUPS-1:0] w_full;

    // captured input item
    t_in_item r_item;

    // acknowledgment store and its read register
    logic [ACK_W-1:0] r_mem [SLOTS];
    logic [ACK_W-1:0] r_rd;

    // output register
    logic      r_out_valid;
    t_out_item r_out;

    logic [CW-1:0]  w_cnt;
    logic [AW-1:0]  w_base;
    logic [AW-1:0]  w_waddr;
    logic [AW-1:0]  w_raddr;
    logic           w_we;
    logic [2:0]     w_rec_status;
    logic [GROUPS-1:0] w_rest;
    logic           w_out_free;

    assign w_cnt  = r_cnt[i_grp];
    assign w_base = AW'(i_grp * ACKS_PER_GROUP);

    // full-group vector for the sweep
    always_comb begin
        for (int g = 0; g < GROUPS; g++) begin
            w_full[g] = (r_cnt[g] == CW'(ACKS_PER_GROUP));
        end
    end

    // lowest pending group of the sweep
    always_comb begin
        o_mask_low = '0;
        for (int g = GROUPS - 1; g >= 0; g--) begin
            if (r_mask[g]) begin
                o_mask_low = GW'(g);
            end
        end
    end

    always_comb begin
        w_rest        = r_mask;
        w_rest[i_grp] = 1'b0;
    end

    // record decision
    always_comb begin
        w_we         = 1'b0;
        w_waddr      = w_base;
        w_rec_status = ST_TABLE_FULL;
        if (r_item.msg_id == 16'd0) begin
            w_rec_status = ST_TABLE_FULL;
        end else if (i_cmd.rec_hit) begin
            if (w_cnt == CW'(ACKS_PER_GROUP)) begin
                w_rec_status = ST_GROUP_FULL;
            end else begin
                w_we    = 1'b1;
                w_waddr = w_base + AW'(w_cnt);
                w_rec_status = (w_cnt == CW'(ACKS_PER_GROUP - 1)) ? ST_COMPLETED : ST_APPENDED;
            end
        end else if (i_cmd.rec_take) begin
            w_we         = 1'b1;
            w_rec_status = ST_NEW_GROUP;
        end
    end

    assign w_raddr    = w_base + AW'(i_slot);
    assign w_out_free = !r_out_valid || !i_out_stall;

    // status to controller
    always_comb begin
        o_stat.in_mode   = i_in_item.mode;
        o_stat.grp_match = (w_cnt != '0) && (r_gid[i_grp] == r_item.msg_id);
        o_stat.grp_free  = (w_cnt == '0);
        o_stat.mask_any  = |r_mask;
        o_stat.rest_zero = (w_rest == '0);
        o_stat.out_free  = w_out_free;
    end

    // input capture
    always_ff @(posedge i_clk) begin
        if (i_cmd.in_load) begin
            r_item <= i_in_item;
        end
    end

    // group counts and sweep mask
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            for (int g = 0; g < GROUPS; g++) begin
                r_cnt[g] <= '0;
            end
            r_mask <= '0;
        end else begin
            if (i_cmd.mask_load) begin
                r_mask <= w_full;
            end
            if (i_cmd.rec_commit && w_we) begin
                r_cnt[i_grp] <= w_cnt + CW'(1);
            end
            if (i_cmd.sw_done) begin
                r_cnt[i_grp]  <= '0;
                r_mask[i_grp] <= 1'b0;
            end
        end
    end

    // group owner ids
    always_ff @(posedge i_clk) begin
        if (i_cmd.rec_commit && w_we && !i_cmd.rec_hit) begin
            r_gid[i_grp] <= r_item.msg_id;
        end
    end

    // acknowledgment store
    always_ff @(posedge i_clk) begin
        if (i_cmd.rec_commit && w_we) begin
            r_mem[w_waddr] <= {r_item.sender_id, r_item.receiver_id, r_item.stamp};
        end
        if (i_cmd.sw_read) begin
            r_rd <= r_mem[w_raddr];
        end
    end

    // output register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (i_cmd.rec_commit || i_cmd.sw_emit || i_cmd.none_emit) begin
            r_out_valid <= 1'b1;
        end else if (!i_out_stall) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.rec_commit) begin
            r_out.status       <= w_rec_status;
            r_out.out_msg_id   <= r_item.msg_id;
            r_out.out_sender   <= r_item.sender_id;
            r_out.out_receiver <= r_item.receiver_id;
            r_out.out_stamp    <= r_item.stamp;
            r_out.last         <= 1'b1;
        end else if (i_cmd.sw_emit) begin
            r_out.status       <= ST_SWEEP;
            r_out.out_msg_id   <= r_gid[i_grp];
            r_out.out_sender   <= r_rd[ACK_W-1 -: 22];
            r_out.out_receiver <= r_rd[ACK_W-23 -: 22];
            r_out.out_stamp    <= r_rd[31:0];
            r_out.last         <= i_cmd.sw_last;
        end else if (i_cmd.none_emit) begin
            r_out.status       <= ST_NONE;
            r_out.out_msg_id   <= '0;
            r_out.out_sender   <= '0;
            r_out.out_receiver <= '0;
            r_out.out_stamp    <= '0;
            r_out.last         <= 1'b1;
        end
    end

    assign o_out_valid = r_out_valid;
    assign o_out_item  = r_out;

endmodule

[rtl/core/gac_ctrl.sv]
module gac_ctrl #(
    parameter int GROUPS         = 8,
    parameter int ACKS_PER_GROUP = 5
) (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_in_valid,
    output logic              o_in_stall,
    input  gac_pkg::t_dp_stat i_stat,
    input  logic [((GROUPS > 1) ? $clog2(GROUPS) : 1)-1:0] i_mask_low,
    output gac_pkg::t_dp_cmd  o_cmd,
    output logic [((GROUPS > 1) ? $clog2(GROUPS) : 1)-1:0] o_grp,
    output logic [$clog2(ACKS_PER_GROUP)-1:0]              o_slot
);
    import gac_pkg::*;

    localparam int GW = (GROUPS > 1) ? $clog2(GROUPS) : 1;
    localparam int SW = $clog2(ACKS_PER_GROUP);

    typedef enum logic [5:0] {
        S_IDLE   = 6'b000001,
        S_SCAN   = 6'b000010,
        S_REC    = 6'b000100,
        S_SW_SEL = 6'b001000,
        S_SW_RD  = 6'b010000,
        S_SW_OUT = 6'b100000
    } t_state;

    t_state        r_state, n_state;
    logic [GW-1:0] r_g, n_g;
    logic [SW-1:0] r_s, n_s;
    logic          r_hit, n_hit;
    logic [GW-1:0] r_hit_g, n_hit_g;
    logic          r_have_free, n_have_free;
    logic [GW-1:0] r_free_g, n_free_g;
    logic          w_accept;
    logic          w_slot_last;

    assign o_in_stall  = (r_state != S_IDLE);
    assign w_accept    = i_in_valid && (r_state == S_IDLE);
    assign w_slot_last = (r_s == SW'(ACKS_PER_GROUP - 1));

    // group index toward the datapath
    always_comb begin
        if (r_state == S_REC) begin
            o_grp = r_hit ? r_hit_g : r_free_g;
        end else begin
            o_grp = r_g;
        end
    end
    assign o_slot = r_s;

    // next state and commands
    always_comb begin
        n_state     = r_state;
        n_g         = r_g;
        n_s         = r_s;
        n_hit       = r_hit;
        n_hit_g     = r_hit_g;
        n_have_free = r_have_free;
        n_free_g    = r_free_g;
        o_cmd       = '0;
        o_cmd.rec_hit  = r_hit;
        o_cmd.rec_take = r_have_free;
        case (r_state)
            S_IDLE: begin
                if (w_accept) begin
                    o_cmd.in_load = 1'b1;
                    n_g           = '0;
                    n_hit         = 1'b0;
                    n_have_free   = 1'b0;
                    if (i_stat.in_mode == MODE_SWEEP) begin
                        o_cmd.mask_load = 1'b1;
                        n_state         = S_SW_SEL;
                    end else begin
                        n_state = S_SCAN;
                    end
                end
            end
            S_SCAN: begin
                // one group a cycle, stop at the owner of the id
                if (i_stat.grp_match) begin
                    n_hit   = 1'b1;
                    n_hit_g = r_g;
                    n_state = S_REC;
                end else begin
                    if (i_stat.grp_free && !r_have_free) begin
                        n_have_free = 1'b1;
                        n_free_g    = r_g;
                    end
                    if (r_g == GW'(GROUPS - 1)) begin
                        n_state = S_REC;
                    end else begin
                        n_g = r_g + GW'(1);
                    end
                end
            end
            S_REC: begin
                if (i_stat.out_free) begin
                    o_cmd.rec_commit = 1'b1;
                    n_state          = S_IDLE;
                end
            end
            S_SW_SEL: begin
                if (i_stat.mask_any) begin
                    n_g     = i_mask_low;
                    n_s     = '0;
                    n_state = S_SW_RD;
                end else if (i_stat.out_free) begin
                    o_cmd.none_emit = 1'b1;
                    n_state         = S_IDLE;
                end
            end
            S_SW_RD: begin
                o_cmd.sw_read = 1'b1;
                n_state       = S_SW_OUT;
            end
            S_SW_OUT: begin
                if (i_stat.out_free) begin
                    o_cmd.sw_emit = 1'b1;
                    o_cmd.sw_last = w_slot_last && i_stat.rest_zero;
                    if (w_slot_last) begin
                        o_cmd.sw_done = 1'b1;
                        n_state       = i_stat.rest_zero ? S_IDLE : S_SW_SEL;
                    end else begin
                        n_s     = r_s + SW'(1);
                        n_state = S_SW_RD;
                    end
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_g         <= '0;
            r_s         <= '0;
            r_hit       <= 1'b0;
            r_hit_g     <= '0;
            r_have_free <= 1'b0;
            r_free_g    <= '0;
        end else begin
            r_state     <= n_state;
            r_g         <= n_g;
            r_s         <= n_s;
            r_hit       <= n_hit;
            r_hit_g     <= n_hit_g;
            r_have_free <= n_have_free;
            r_free_g    <= n_free_g;
        end
    end

endmodule

[rtl/core/grouped_ack_collector.sv]
// record beat: accept, then a scan of the groups in order (up to GROUPS, stopping at the
// owner of the id), then a commit that registers the result once the output is free
// sweep beat: a select step per complete group plus a store read and an output step
// per emitted acknowledgment; the group scan and the single store read port set the pace
// one item in flight at a time; the next is taken once the previous one is committed
// synchronous active-low reset frees every group and empties the output; no clearing pass
module grouped_ack_collector #(
    parameter int GROUPS         = 8,
    parameter int ACKS_PER_GROUP = 5
) (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_in_valid,
    output logic               o_in_stall,
    input  gac_pkg::t_in_item  i_in_item,
    output logic               o_out_valid,
    input  logic               i_out_stall,
    output gac_pkg::t_out_item o_out_item
);
    import gac_pkg::*;

    localparam int GW = (GROUPS > 1) ? $clog2(GROUPS) : 1;
    localparam int SW = $clog2(ACKS_PER_GROUP);

    t_dp_cmd       w_cmd;
    t_dp_stat      w_stat;
    logic [GW-1:0] w_grp;
    logic [GW-1:0] w_mask_low;
    logic [SW-1:0] w_slot;

    // sequencer
    gac_ctrl #(
        .GROUPS         (GROUPS),
        .ACKS_PER_GROUP (ACKS_PER_GROUP)
    ) u_ctrl (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in_valid (i_in_valid),
        .o_in_stall (o_in_stall),
        .i_stat     (w_stat),
        .i_mask_low (w_mask_low),
        .o_cmd      (w_cmd),
        .o_grp      (w_grp),
        .o_slot     (w_slot)
    );

    // group table, store and output register
    gac_datapath #(
        .GROUPS         (GROUPS),
        .ACKS_PER_GROUP (ACKS_PER_GROUP)
    ) u_dp (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_item   (i_in_item),
        .i_out_stall (i_out_stall),
        .o_out_valid (o_out_valid),
        .o_out_item  (o_out_item),
        .i_cmd       (w_cmd),
        .i_grp       (w_grp),
        .i_slot      (w_slot),
        .o_stat      (w_stat),
        .o_mask_low  (w_mask_low)
    );

endmodule

[rtl/core/gac_checker.sv]
module gac_checker (
    input logic               i_clk,
    input logic               i_rst_n,
    input logic               i_in_valid,
    input logic               o_in_stall,
    input gac_pkg::t_in_item  i_in_item,
    input logic               o_out_valid,
    input logic               i_out_stall,
    input gac_pkg::t_out_item o_out_item
);
    import gac_pkg::*;

    // a stalled result beat holds
    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && i_out_stall |=> o_out_valid && $stable(o_out_item))
        else $error("result beat changed under stall");

    // reset leaves the block empty and ready
    a_reset: assert property (@(posedge i_clk)
        !i_rst_n |=> !o_out_valid && !o_in_stall)
        else $error("block not empty after reset");

    // an accepted beat keeps the block busy next cycle
    a_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_in_valid && !o_in_stall |=> o_in_stall)
        else $error("input taken again without processing");

    // record results and the empty sweep close their item
    a_single_last: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && (o_out_item.status == ST_APPENDED ||
        o_out_item.status == ST_NEW_GROUP || o_out_item.status == ST_COMPLETED ||
        o_out_item.status == ST_TABLE_FULL || o_out_item.status == ST_GROUP_FULL ||
        o_out_item.status == ST_NONE) |-> o_out_item.last)
        else $error("single-result beat without last");

    // the empty sweep carries no acknowledgment
    a_none_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && o_out_item.status == ST_NONE |->
        o_out_item.out_msg_id == '0 && o_out_item.out_stamp == '0)
        else $error("empty sweep result carries data");

endmodule

bind grouped_ack_collector gac_checker u_gac_checker (.*);
